// ===== hw/rtl/ncas_pkg.sv =====
// ----------------------------------------------------------------------------
// ncas_pkg
// Shared widths, codes and types of the nearest-centroid assignment block.
// ----------------------------------------------------------------------------
package ncas_pkg;

  localparam int ACC_W     = 40;
  localparam int DIST_W    = 39;
  localparam int CLUSTER_W = 4;
  localparam int DIM_W     = 7;
  localparam int ACTIVE_W  = 5;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd10;
  localparam logic [ACC_W-1:0]    ACC_MAX      = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0]   DIST_MAX     = {DIST_W{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // control carried alongside one centroid through the distance unit
  typedef struct packed {
    logic vld;
    logic dim_ok;
    logic acc_ok;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/ncas_ram.sv =====
// ----------------------------------------------------------------------------
// ncas_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ncas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ncas_dist_unit.sv =====
// ----------------------------------------------------------------------------
// ncas_dist_unit
// Shared subtract-square-accumulate pipeline, one centroid per cycle:
// difference and magnitude, square, saturating add.
// ----------------------------------------------------------------------------
module ncas_dist_unit #(
  parameter int COORD_BITS = 16,
  parameter int CW         = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ncas_pkg::lane_ctl_t           ctl_in,
  input  logic [CW-1:0]                 cl_in,
  input  logic signed [COORD_BITS-1:0]  x,
  input  logic [COORD_BITS-1:0]         cent,
  input  logic [ncas_pkg::ACC_W-1:0]    acc_in,
  output logic                          res_vld,
  output logic [CW-1:0]                 res_cl,
  output logic [ncas_pkg::ACC_W-1:0]    res_acc
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = (SQ_W > ncas_pkg::ACC_W ? SQ_W : ncas_pkg::ACC_W) + 1;

  logic [COORD_BITS:0]          diff;
  logic [COORD_BITS:0]          diff_abs;
  logic [SUM_W-1:0]             sum;

  logic                         vld1, vld2;
  logic                         dim_ok1;
  logic [CW-1:0]                cl1, cl2;
  logic [COORD_BITS-1:0]        mag1;
  logic [ncas_pkg::ACC_W-1:0]   acc1, acc2;
  logic [SQ_W-1:0]              sq2;

  assign diff     = {x[COORD_BITS-1], x} - {cent[COORD_BITS-1], cent};
  assign diff_abs = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
  assign sum      = SUM_W'(acc2) + SUM_W'(sq2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      vld1    <= ctl_in.vld;
      vld2    <= vld1;
      res_vld <= vld2;
    end
    // magnitude stage
    mag1    <= diff_abs[COORD_BITS-1:0];
    acc1    <= ctl_in.acc_ok ? acc_in : '0;
    dim_ok1 <= ctl_in.dim_ok;
    cl1     <= cl_in;
    // square stage
    sq2     <= dim_ok1 ? SQ_W'(mag1 * mag1) : '0;
    acc2    <= acc1;
    cl2     <= cl1;
    // saturating accumulate stage
    res_acc <= (sum > SUM_W'(ncas_pkg::ACC_MAX)) ? ncas_pkg::ACC_MAX
                                                 : sum[ncas_pkg::ACC_W-1:0];
    res_cl  <= cl2;
  end

endmodule

// ===== hw/rtl/nearest_centroid_assign.sv =====
// ----------------------------------------------------------------------------
// nearest_centroid_assign
// k-means assignment step: nearest centroid by squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes active_clusters (k); 0 acts as 1, values above
//   MAX_CLUSTERS act as MAX_CLUSTERS. Write it only while the block is idle.
//   Input transactions with opcode load write one centroid coordinate into
//   the centroid store and leave the block idle. Point transactions run every
//   active centroid through one shared subtract-square-accumulate pipeline,
//   one centroid per cycle: each issue reads the centroid and accumulator
//   stores, the pipeline adds the squared difference, and the block drains
//   until the last active centroid is written back, then returns to idle.
//   A coordinate marked point_last first passes the wrap-up step, where the
//   result is registered. in_ready is low while a point coordinate is in work.
//   The result (best_cluster, min_distance) goes to an output register and
//   the accumulators clear. A stalled receiver does not block the next
//   transaction; only a second result waits in the wrap-up step until the
//   output register frees. Reset sets k to 10 and clears all accumulators
//   and control state; the centroid store holds nothing defined until written.
// ----------------------------------------------------------------------------
module nearest_centroid_assign #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 128,
  parameter int COORD_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [ncas_pkg::CLUSTER_W-1:0]      centroid_index,
  input  logic [ncas_pkg::DIM_W-1:0]          dim_index,
  input  logic signed [COORD_BITS-1:0]        coord_value,
  input  logic                                point_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ncas_pkg::CLUSTER_W-1:0]      best_cluster,
  output logic [ncas_pkg::DIST_W-1:0]         min_distance,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ncas_pkg::ACTIVE_W-1:0]       cfg_data
);

  localparam int CW          = $clog2(MAX_CLUSTERS);
  localparam int DW          = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
  localparam int STORE_DEPTH = MAX_CLUSTERS * (2 ** DW);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                       state;
  logic [ncas_pkg::ACTIVE_W-1:0]    active_clusters;
  logic                             accept;
  logic                             ci_ok, di_ok;
  logic                             store_we;
  logic [CW-1:0]                    k_last_next;

  logic signed [COORD_BITS-1:0]     x_q;
  logic [DW-1:0]                    dim_q;
  logic                             dim_ok_q;
  logic                             last_q;
  logic [CW-1:0]                    k_last;
  logic [CW-1:0]                    cnt;

  logic [MAX_CLUSTERS-1:0]          acc_valid;
  ncas_pkg::lane_ctl_t              ctl_v1;
  logic [CW-1:0]                    cl_v1;

  logic [COORD_BITS-1:0]            cent_rd;
  logic [ncas_pkg::ACC_W-1:0]       acc_rd;
  logic                             res_vld;
  logic [CW-1:0]                    res_cl;
  logic [ncas_pkg::ACC_W-1:0]       res_acc;

  logic [CW-1:0]                    best_c;
  logic [ncas_pkg::ACC_W-1:0]       best_d;
  logic                             out_free;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign ci_ok     = int'(centroid_index) < MAX_CLUSTERS;
  assign di_ok     = int'(dim_index) < MAX_DIMS;
  assign store_we  = accept && (opcode == ncas_pkg::OP_LOAD) && ci_ok && di_ok;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    priority if (active_clusters == '0) begin
      k_last_next = '0;
    end else if (int'(active_clusters) > MAX_CLUSTERS) begin
      k_last_next = CW'(MAX_CLUSTERS - 1);
    end else begin
      k_last_next = CW'(active_clusters - 1'b1);
    end
  end

  ncas_ram #(
    .WIDTH (COORD_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_centroid_store (
    .clk   (clk),
    .we    (store_we),
    .waddr ({CW'(centroid_index), DW'(dim_index)}),
    .wdata (coord_value),
    .raddr ({cnt, dim_q}),
    .rdata (cent_rd)
  );

  ncas_ram #(
    .WIDTH (ncas_pkg::ACC_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_acc_store (
    .clk   (clk),
    .we    (res_vld),
    .waddr (res_cl),
    .wdata (res_acc),
    .raddr (cnt),
    .rdata (acc_rd)
  );

  ncas_dist_unit #(
    .COORD_BITS (COORD_BITS),
    .CW         (CW)
  ) u_dist_unit (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_v1),
    .cl_in   (cl_v1),
    .x       (x_q),
    .cent    (cent_rd),
    .acc_in  (acc_rd),
    .res_vld (res_vld),
    .res_cl  (res_cl),
    .res_acc (res_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      active_clusters <= ncas_pkg::ACTIVE_RESET;
      acc_valid       <= '0;
      ctl_v1          <= '0;
      out_valid       <= 1'b0;
      cnt             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_clusters <= cfg_data;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      ctl_v1.vld <= (state == ST_RUN);
      if (res_vld) begin
        acc_valid[res_cl] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && opcode == ncas_pkg::OP_POINT) begin
            cnt   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          ctl_v1.dim_ok <= dim_ok_q;
          ctl_v1.acc_ok <= acc_valid[cnt];
          cnt           <= cnt + 1'b1;
          if (cnt == k_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res_vld && res_cl == k_last) begin
            state <= last_q ? ST_FINISH : ST_IDLE;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            acc_valid <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q      <= coord_value;
      dim_q    <= DW'(dim_index);
      dim_ok_q <= di_ok;
      last_q   <= point_last;
      k_last   <= k_last_next;
    end
    cl_v1 <= cnt;
    // running minimum, strict compare keeps the lowest index on ties
    if (res_vld && (res_cl == '0 || res_acc < best_d)) begin
      best_c <= res_cl;
      best_d <= res_acc;
    end
    if (state == ST_FINISH && out_free) begin
      best_cluster <= ncas_pkg::CLUSTER_W'(best_c);
      min_distance <= (best_d > ncas_pkg::ACC_W'(ncas_pkg::DIST_MAX))
                      ? ncas_pkg::DIST_MAX : best_d[ncas_pkg::DIST_W-1:0];
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ctl_v1.vld && !res_vld)
    else $error("distance pipeline busy while accepting");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> cnt <= k_last)
    else $error("issue counter past last active centroid");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (acc_valid == '0) && out_valid)
    else $error("result emitted without clearing accumulators");

  a_result_in_pass: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("accumulator write outside a pass");

endmodule
